// File: hw/rtl/pose_stability_detector_assert.svh
// Assertion macros used by the pose stability detector RTL
`ifndef POSE_STABILITY_DETECTOR_ASSERT_SVH
`define POSE_STABILITY_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clock, off during reset
`define PSD_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pose stability detector: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset
`define PSD_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pose stability detector: next-cycle check failed");

`else

`define PSD_ASSERT_IMP(label, ante, cons)
`define PSD_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/psd_pkg.sv
// Shared constants and types of the pose stability detector
`default_nettype none

package psd_pkg;

   // Field widths
   localparam int POS_W   = 24;
   localparam int DIFF_W  = POS_W + 1;
   localparam int SQ_W    = 2 * DIFF_W;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int SUM_W   = 28;
   localparam int LIMIT_W = 28;

   // Defaults
   localparam int                 PSD_WINDOW   = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(40000);
   localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};

   // Axis codes for the shared squaring unit
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       sq_en;
      logic [1:0] axis;
      logic       rt_step;
      logic       commit;
   } psd_cmd_type;

endpackage

`default_nettype wire

// File: hw/rtl/pose_stability_detector.sv
// From item accept to rsp_valid an item goes through squaring of the three axes,
// the square root and the window update. One item is worked on at a time, paced by
// the one-bit-per-cycle root and the single multiplier shared over the three axes.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) clears the window, step ring, sum and count,
// and loads motion_limit with 40000.
`default_nettype none

module pose_stability_detector #(
   parameter int WINDOW = psd_pkg::PSD_WINDOW
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_x,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_y,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_z,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_stable,
   output logic       [psd_pkg::SUM_W-1:0]    rsp_total_motion,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire        [psd_pkg::LIMIT_W-1:0]  csr_motion_limit
);

   psd_pkg::psd_cmd_type cmd;

   // Sequencer
   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Arithmetic and window state
   psd_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_motion_limit (csr_motion_limit),
      .rsp_stable       (rsp_stable),
      .rsp_total_motion (rsp_total_motion)
   );

endmodule

`default_nettype wire

// File: hw/rtl/psd_ctrl.sv
// Sequencer of the pose stability detector: handshake, steps, output valid
`default_nettype none

`include "pose_stability_detector_assert.svh"

module psd_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output psd_pkg::psd_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SQR  = 2'd1;
   localparam logic [1:0] ST_ROOT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int CNT_W = $clog2(psd_pkg::ROOT_W);
   localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(psd_pkg::ROOT_W - 1);
   localparam logic [CNT_W-1:0] SQR_LAST  = CNT_W'(psd_pkg::AXIS_Z);

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   // Output slot can take a result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Commands
   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.sq_en   = (state_ff == ST_SQR);
      cmd.axis    = cnt_ff[1:0];
      cmd.rt_step = (state_ff == ST_ROOT);
      cmd.commit  = (state_ff == ST_DONE) && out_free;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (cnt_ff == SQR_LAST) begin
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Output valid: set on commit, held while stalled
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   `PSD_ASSERT_NXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_SQR)
   `PSD_ASSERT_NXT(a_commit_shows, cmd.commit, rsp_valid_ff)
   `PSD_ASSERT_NXT(a_done_waits, (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall,
                   state_ff == ST_DONE)
   `PSD_ASSERT_IMP(a_root_count, state_ff == ST_ROOT, cnt_ff <= ROOT_LAST)

endmodule

`default_nettype wire

// File: hw/rtl/psd_datapath.sv
// Datapath: squares, bitwise square root, step ring, running sum, result register
`default_nettype none

module psd_datapath #(
   parameter int WINDOW = psd_pkg::PSD_WINDOW
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire psd_pkg::psd_cmd_type          cmd,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_x,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_y,
   input  wire signed [psd_pkg::POS_W-1:0]    req_pos_z,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire        [psd_pkg::LIMIT_W-1:0]  csr_motion_limit,
   output logic                               rsp_stable,
   output logic       [psd_pkg::SUM_W-1:0]    rsp_total_motion
);

   localparam int POS_W  = psd_pkg::POS_W;
   localparam int DIFF_W = psd_pkg::DIFF_W;
   localparam int SQ_W   = psd_pkg::SQ_W;
   localparam int ROOT_W = psd_pkg::ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int SUM_W  = psd_pkg::SUM_W;
   localparam int STEPS  = WINDOW - 1;
   localparam int SLOT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int FR_W   = $clog2(WINDOW + 2);
   localparam int TOT_W  = ROOT_W + $clog2(WINDOW);
   localparam int EXT_W  = (TOT_W > SUM_W) ? TOT_W : SUM_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(STEPS - 1);
   localparam logic [FR_W-1:0]   FR_FULL   = FR_W'(WINDOW + 1);

   logic signed [POS_W-1:0]  cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [POS_W-1:0]  last_x_ff, last_y_ff, last_z_ff;
   logic [SQ_W-1:0]          acc_ff, acc_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [ROOT_W-1:0]        root_ff, root_in;
   logic [ROOT_W-1:0]        ring_ff [STEPS];
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [FR_W-1:0]          frames_ff, frames_in;
   logic [TOT_W-1:0]         total_ff, total_in;
   logic [psd_pkg::LIMIT_W-1:0] limit_ff;

   logic signed [POS_W-1:0]  sel_cur, sel_last;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        mag;
   logic [SQ_W-1:0]          prod;
   logic [REM_W-1:0]         rem_shift, trial;
   logic                     first;
   logic [EXT_W-1:0]         total_ext;
   logic [SUM_W-1:0]         total_sat;

   assign csr_ready = 1'b1;

   // Axis select for the shared squaring unit
   always_comb begin
      case (cmd.axis)
         psd_pkg::AXIS_X: begin
            sel_cur  = cur_x_ff;
            sel_last = last_x_ff;
         end
         psd_pkg::AXIS_Y: begin
            sel_cur  = cur_y_ff;
            sel_last = last_y_ff;
         end
         psd_pkg::AXIS_Z: begin
            sel_cur  = cur_z_ff;
            sel_last = last_z_ff;
         end
         default: begin
            sel_cur  = cur_x_ff;
            sel_last = last_x_ff;
         end
      endcase
   end

   // Difference, magnitude and square
   assign diff = {sel_cur[POS_W-1], sel_cur} - {sel_last[POS_W-1], sel_last};
   assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign prod = mag * mag;

   // One root bit per step: bring down two radicand bits, try 4*root+1
   assign rem_shift = {rem_ff[REM_W-3:0], acc_ff[SQ_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.load) begin
         acc_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sq_en) begin
         acc_in = acc_ff + prod;
      end else if (cmd.rt_step) begin
         acc_in = {acc_ff[SQ_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Window bookkeeping on commit
   assign first     = (frames_ff == '0);
   assign slot_in   = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
   assign frames_in = (frames_ff == FR_FULL) ? frames_ff : frames_ff + 1'b1;
   assign total_in  = first ? total_ff
                            : total_ff - TOT_W'(ring_ff[slot_ff]) + TOT_W'(root_ff);

   // Saturate the window sum to the result width
   assign total_ext = EXT_W'(total_in);
   assign total_sat = (total_ext > EXT_W'(psd_pkg::SUM_MAX)) ? psd_pkg::SUM_MAX
                                                            : total_ext[SUM_W-1:0];

   // Item capture and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= req_pos_x;
         cur_y_ff <= req_pos_y;
         cur_z_ff <= req_pos_z;
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (cmd.commit) begin
         rsp_total_motion <= total_sat;
         rsp_stable       <= (frames_in == FR_FULL) && (total_sat < limit_ff);
      end
   end

   // Window state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
         last_z_ff <= '0;
         for (int i = 0; i < STEPS; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff   <= '0;
         frames_ff <= '0;
         total_ff  <= '0;
         limit_ff  <= psd_pkg::LIMIT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_motion_limit;
         end
         if (cmd.commit) begin
            last_x_ff <= cur_x_ff;
            last_y_ff <= cur_y_ff;
            last_z_ff <= cur_z_ff;
            frames_ff <= frames_in;
            total_ff  <= total_in;
            if (!first) begin
               ring_ff[slot_ff] <= root_ff;
               slot_ff          <= slot_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking testbench for the pose stability detector
module testbench;

   localparam int WINDOW          = psd_pkg::PSD_WINDOW;
   localparam int STEPS           = WINDOW - 1;
   localparam int POS_W           = psd_pkg::POS_W;
   localparam int SUM_W           = psd_pkg::SUM_W;
   localparam int LIMIT_W         = psd_pkg::LIMIT_W;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int NUM_PHASES      = 7;
   localparam int MAX_REPORTS     = 10;
   localparam int EXPECT_DEPTH    = 64;
   localparam int DIRECTED_MAX    = 32;

   typedef logic signed [POS_W-1:0] coord_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } pose_type;
   typedef struct packed {
      logic             stable;
      logic [SUM_W-1:0] total;
   } verdict_type;
   typedef struct packed {
      pose_type    pose;
      logic        typed;
      verdict_type verdict;
   } pose_row_type;

   localparam coord_type POS_MAX = coord_type'(8388607);
   localparam coord_type POS_MIN = coord_type'(-8388608);

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   coord_type           req_pos_x = '0;
   coord_type           req_pos_y = '0;
   coord_type           req_pos_z = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_stable;
   logic [SUM_W-1:0]    rsp_total_motion;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LIMIT_W-1:0]  csr_motion_limit = '0;

   // Receiver control, driven from the main sequence
   logic                receiver_idles = 1'b1;
   logic                hold_trig = 1'b0;
   logic                hold_seen = 1'b0;
   int                  hold_left = 0;
   bit                  sender_idles = 1'b1;

   // Predictor state
   pose_type            prev_pose = '0;
   logic [24:0]         steps [STEPS];
   int unsigned         step_slot = 0;
   int unsigned         poses_seen = 0;
   logic [LIMIT_W-1:0]  limit_copy = psd_pkg::LIMIT_RESET;

   // Expected results in order, written at exp_tail, read at exp_head
   verdict_type         expected_verdicts [EXPECT_DEPTH];
   int                  exp_head = 0;
   int                  exp_tail = 0;

   pose_row_type        directed_poses [DIRECTED_MAX];
   int                  directed_count = 0;

   int                  cycle_count = 0;
   int                  items_sent = 0;
   int                  results_checked = 0;
   int                  stable_seen = 0;
   int                  mismatches = 0;
   int                  limit_writes = 0;

   pose_stability_detector #(.WINDOW(WINDOW)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_stable       (rsp_stable),
      .rsp_total_motion (rsp_total_motion),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_motion_limit (csr_motion_limit)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Floor square root, one result bit at a time from the top
   function automatic logic [24:0] floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 25; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root[24:0];
   endfunction

   // Advance the window by one pose and return the expected verdict
   function automatic verdict_type track_pose(input pose_type p);
      longint          dx;
      longint          dy;
      longint          dz;
      longint unsigned d2;
      int unsigned     acc;
      verdict_type     v;
      if (poses_seen > 0) begin
         dx = longint'(p.x) - longint'(prev_pose.x);
         dy = longint'(p.y) - longint'(prev_pose.y);
         dz = longint'(p.z) - longint'(prev_pose.z);
         d2 = dx * dx + dy * dy + dz * dz;
         steps[step_slot] = floor_root(d2);
         step_slot = (step_slot + 1) % STEPS;
      end
      prev_pose = p;
      if (poses_seen < WINDOW + 1) poses_seen++;
      acc = 0;
      foreach (steps[i]) begin
         acc += steps[i];
         if (acc > psd_pkg::SUM_MAX) acc = psd_pkg::SUM_MAX;
      end
      v.total  = acc[SUM_W-1:0];
      v.stable = (poses_seen >= WINDOW + 1) && (acc < limit_copy);
      return v;
   endfunction

   // Next pose of a random walk: mostly still or small moves, some jumps
   function automatic pose_type wander(input pose_type p);
      int unsigned kind;
      pose_type    n;
      kind = $urandom_range(99);
      n = p;
      if (kind < 15) begin
         n = p;
      end else if (kind < 65) begin
         n.x = coord_type'(int'(p.x) + int'($urandom_range(128)) - 64);
         n.y = coord_type'(int'(p.y) + int'($urandom_range(128)) - 64);
         n.z = coord_type'(int'(p.z) + int'($urandom_range(128)) - 64);
      end else if (kind < 85) begin
         n.x = coord_type'(int'(p.x) + int'($urandom_range(8192)) - 4096);
         n.y = coord_type'(int'(p.y) + int'($urandom_range(8192)) - 4096);
         n.z = coord_type'(int'(p.z) + int'($urandom_range(8192)) - 4096);
      end else if (kind < 95) begin
         n.x = coord_type'($urandom);
         n.y = coord_type'($urandom);
         n.z = coord_type'($urandom);
      end else begin
         // one axis slams to an end of its range
         case ($urandom_range(2))
            0: n.x = $urandom_range(1) ? POS_MAX : POS_MIN;
            1: n.y = $urandom_range(1) ? POS_MAX : POS_MIN;
            default: n.z = $urandom_range(1) ? POS_MAX : POS_MIN;
         endcase
      end
      return n;
   endfunction

   task automatic add_row(input int x, input int y, input int z, input logic typed,
                          input logic stable, input int total);
      pose_row_type r;
      r.pose.x         = coord_type'(x);
      r.pose.y         = coord_type'(y);
      r.pose.z         = coord_type'(z);
      r.typed          = typed;
      r.verdict.stable = stable;
      r.verdict.total  = SUM_W'(total);
      directed_poses[directed_count] = r;
      directed_count++;
   endtask

   // Offer one pose, wait for acceptance, record what should come back
   task automatic offer_pose(input pose_type p, input logic typed,
                             input verdict_type typed_v);
      verdict_type v;
      while (sender_idles && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= p.x;
      req_pos_y <= p.y;
      req_pos_z <= p.z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = track_pose(p);
      expected_verdicts[exp_tail % EXPECT_DEPTH] = typed ? typed_v : v;
      exp_tail++;
      items_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (exp_tail != exp_head) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_results_drained();
      csr_valid        <= 1'b1;
      csr_motion_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      limit_copy = value;
      limit_writes++;
   endtask

   // Receiver: random stalls, plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= hold_trig;
      end else if (hold_trig != hold_seen) begin
         hold_seen <= hold_trig;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < 30);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (rsp_stable) stable_seen++;
         if (exp_tail == exp_head) begin
            if (mismatches < MAX_REPORTS)
               $display("result with nothing pending: stable=%0b total=%0d",
                        rsp_stable, rsp_total_motion);
            mismatches++;
         end else begin
            want = expected_verdicts[exp_head % EXPECT_DEPTH];
            exp_head++;
            if (rsp_stable !== want.stable || rsp_total_motion !== want.total) begin
               if (mismatches < MAX_REPORTS)
                  $display("mismatch at result %0d: stable exp %0b got %0b, %s %0d got %0d",
                           results_checked, want.stable, rsp_stable, "total exp",
                           want.total, rsp_total_motion);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  exp_tail - exp_head);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : main_sequence
      pose_type           walk;
      logic [LIMIT_W-1:0] lim;
      foreach (steps[i]) steps[i] = '0;

      // Directed poses; expected values typed only where they are obvious
      add_row(0, 0, 0, 1'b1, 1'b0, 0);                          // first pose: no step
      add_row(8388607, 0, 0, 1'b1, 1'b0, 8388607);
      add_row(-8388608, 0, 0, 1'b1, 1'b0, 25165822);            // full-range x step
      add_row(-8388608, -8388608, -8388608, 1'b0, 1'b0, 0);
      add_row(8388607, 8388607, 8388607, 1'b0, 1'b0, 0);        // full diagonal
      add_row(8388607, 8388607, 8388607, 1'b0, 1'b0, 0);        // window now full
      add_row(8388607, 8388607, 8388607, 1'b0, 1'b0, 0);
      add_row(8388607, 8388607, 8388607, 1'b0, 1'b0, 0);
      add_row(8388607, 8388607, 8388607, 1'b1, 1'b1, 0);        // ring flushed to zero
      add_row(8378607, 8388607, 8388607, 1'b0, 1'b0, 0);
      add_row(8368607, 8388607, 8388607, 1'b0, 1'b0, 0);
      add_row(8358607, 8388607, 8388607, 1'b0, 1'b0, 0);
      add_row(8348607, 8388607, 8388607, 1'b1, 1'b0, 40000);    // equal to limit
      add_row(8348607, 8388607, 8388607, 1'b1, 1'b1, 30000);    // just under
      add_row(8348607, 8385607, 8384607, 1'b1, 1'b1, 25000);    // 3-4-5 step
      add_row(8348608, 8385608, 8384607, 1'b0, 1'b0, 0);        // root rounds down
      add_row(8348608, 8385608, 8384607, 1'b0, 1'b0, 0);
      add_row(-8388608, -8388608, -8388608, 1'b0, 1'b0, 0);
      add_row(8388607, -8388608, 0, 1'b0, 1'b0, 0);
      add_row(-1, -1, -1, 1'b0, 1'b0, 0);
      add_row(0, 0, 0, 1'b0, 1'b0, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < directed_count; i++)
         offer_pose(directed_poses[i].pose, directed_poses[i].typed,
                    directed_poses[i].verdict);

      // Random phases, each under its own motion limit
      walk = directed_poses[directed_count - 1].pose;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: lim = '0;
            1: lim = psd_pkg::SUM_MAX;
            2: lim = LIMIT_W'($urandom_range(2000, 200));
            3: lim = psd_pkg::LIMIT_RESET;
            4: lim = LIMIT_W'(1);
            5: lim = LIMIT_W'($urandom);
            default: lim = LIMIT_W'($urandom_range(600, 50));
         endcase
         write_limit(lim);
         // phase 3 runs with no idling on either side
         sender_idles = (ph != 3);
         receiver_idles <= (ph != 3);
         if (ph == 2) hold_trig <= ~hold_trig;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (ph == 4 && i == ITEMS_PER_PHASE / 2) wait_results_drained();
            walk = wander(walk);
            offer_pose(walk, 1'b0, '0);
         end
         receiver_idles <= 1'b1;
      end

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d poses (%0d directed) under %0d motion limits,",
               items_sent, directed_count, limit_writes);
      $display("zero and full scale among them; checked %0d results, %0d stable, %0d mismatches",
               results_checked, stable_seen, mismatches);
      if (mismatches == 0 && exp_tail == exp_head) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
